// ===== src/vrt_pkg.sv =====
// ---------------------------------------------------------------------------
// vrt_pkg: shared types and constants for the velocity rescaling thermostat
// Item and result payloads, controller/datapath command and status groups,
// register indexes and the fixed-point constants of the scale factor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

  localparam int TimeW   = 48;
  localparam int EnergyW = 48;
  localparam int VelW    = 32;
  localparam int BetaW   = 24;
  localparam int TempW   = 32;
  localparam int CountW  = 24;
  localparam int CfgW    = 48;

  // Divider produces the 48-bit radicand one bit a step; the root yields
  // one bit for every two radicand bits.
  localparam int DivSteps  = 48;
  localparam int SqrtSteps = 24;
  localparam int StepW     = $clog2(DivSteps);

  localparam logic [BetaW-1:0] BetaOne = 24'h100000;
  localparam logic [BetaW-1:0] BetaMax = 24'hFFFFFF;
  localparam logic [TimeW-1:0] FireIntervalReset = 48'd65536;
  localparam logic [CountW-1:0] ParticleCountReset = 24'd1;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_TARGET   = 2'd1,
    CFG_INTERVAL = 2'd2,
    CFG_COUNT    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_BEGIN    = 1'b0,
    MODE_VELOCITY = 1'b1
  } mode_t;

  typedef struct packed {
    logic                     mode;
    logic [TimeW-1:0]         sim_time;
    logic [EnergyW-1:0]       kinetic_energy;
    logic signed [VelW-1:0]   velocity_in;
  } item_t;

  typedef struct packed {
    logic signed [VelW-1:0]   velocity_out;
    logic                     fired;
    logic [BetaW-1:0]         scale_factor_out;
  } result_t;

  typedef struct packed {
    logic vel_load;
    logic beg_load;
    logic mul_go;
    logic div_init;
    logic div_step;
    logic sqrt_step;
    logic fin;
    logic sat_fin;
    logic out_vel;
    logic out_beg;
  } cmd_t;

  typedef struct packed {
    logic item_mode;
    logic due;
    logic sat;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/velocity_rescale_thermostat.sv =====
// Velocity items are taken one per cycle while the result register is free; each result is
// registered from the product, which is registered when the item is accepted.
// A begin step that is not due loads its result once the result register is free, taking no item meanwhile.
// A firing begin step runs one multiply, one range check, 48 divider steps, 24 root steps,
// one update and the result load; a saturated beta goes from the range check to the update and result load.
// Synchronous reset restores the register defaults, clears the schedule and disarms scaling.
// ---------------------------------------------------------------------------
// velocity_rescale_thermostat: velocity rescaling thermostat
// Computes beta = sqrt(target * 3N / (2 * Ek)) on due begin steps and scales
// the velocity components that follow while rescaling is armed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module velocity_rescale_thermostat (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire vrt_pkg::item_t            item,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output vrt_pkg::result_t               result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [vrt_pkg::CfgW-1:0]  cfg_data
);

  vrt_pkg::cmd_t    cmd;
  vrt_pkg::status_t status;

  assign cfg_ready = 1'b1;

  vrt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  vrt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  // Only one working command at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.vel_load, cmd.beg_load, cmd.mul_go, cmd.div_init,
              cmd.div_step, cmd.sqrt_step, cmd.fin, cmd.sat_fin}))
    else $error("more than one datapath command issued");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_vel || cmd.out_beg) |-> status.out_free)
    else $error("result register loaded while a result waits");

  // No item is taken while the divider or the root is running.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.sqrt_step) |-> item_stall)
    else $error("item accepted during beta computation");

  // A begin-step result carries a zero velocity.
  a_begin_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.out_beg |=> (result_valid && (result.velocity_out == '0)))
    else $error("begin-step result malformed");

endmodule

`default_nettype wire

// ===== src/vrt_ctrl.sv =====
// ---------------------------------------------------------------------------
// vrt_ctrl: thermostat sequencer
// Accepts items, steers velocity items through the scaling stage and runs
// the multiply, divide and square-root sequence of a firing begin step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire vrt_pkg::status_t  status,
  output vrt_pkg::cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VEL,
    S_MUL,
    S_CHK,
    S_DIV,
    S_SQRT,
    S_FIN,
    S_BOUT
  } state_t;

  localparam logic [vrt_pkg::StepW-1:0] DivLast  = vrt_pkg::StepW'(vrt_pkg::DivSteps - 1);
  localparam logic [vrt_pkg::StepW-1:0] SqrtLast = vrt_pkg::StepW'(vrt_pkg::SqrtSteps - 1);

  state_t                     state, state_next;
  logic [vrt_pkg::StepW-1:0]  cnt, cnt_next;
  logic                       take_ok;
  logic                       acc;

  always_comb begin
    take_ok    = (state == S_IDLE) || ((state == S_VEL) && status.out_free);
    item_stall = !take_ok;
    acc        = item_valid && take_ok;
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;

    unique case (state)
      S_IDLE: begin
      end
      S_VEL: begin
        if (status.out_free) begin
          cmd.out_vel = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (status.sat) begin
          cmd.sat_fin = 1'b1;
          state_next  = S_BOUT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DivLast) begin
          cnt_next   = '0;
          state_next = S_SQRT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == SqrtLast) begin
          cnt_next   = '0;
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_BOUT;
      end
      S_BOUT: begin
        if (status.out_free) begin
          cmd.out_beg = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (acc) begin
      if (status.item_mode == vrt_pkg::MODE_VELOCITY) begin
        cmd.vel_load = 1'b1;
        state_next   = S_VEL;
      end else begin
        cmd.beg_load = 1'b1;
        state_next   = status.due ? S_MUL : S_BOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/vrt_datapath.sv =====
// ---------------------------------------------------------------------------
// vrt_datapath: thermostat datapath
// Configuration registers, fire schedule, restoring divider, digit-by-digit
// square root, velocity multiply with rounding and saturation, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrt_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [vrt_pkg::CfgW-1:0]    cfg_data,
  input  wire vrt_pkg::item_t              item,
  output vrt_pkg::result_t                 result,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  input  wire vrt_pkg::cmd_t               cmd,
  output vrt_pkg::status_t                 status
);

  localparam int NumW  = vrt_pkg::TempW + vrt_pkg::CountW + 2;
  localparam int ProdW = vrt_pkg::VelW + vrt_pkg::BetaW;

  // Configuration.
  logic                          enable;
  logic [vrt_pkg::TempW-1:0]     target;
  logic [vrt_pkg::TimeW-1:0]     interval;
  logic [vrt_pkg::CountW-1:0]    count;

  // Architectural state.
  logic [vrt_pkg::TimeW-1:0]     nft;
  logic [vrt_pkg::BetaW-1:0]     sf;
  logic                          armed;

  // Begin-step working registers.
  logic [vrt_pkg::EnergyW-1:0]   ek;
  logic [NumW-1:0]               num;
  logic [vrt_pkg::EnergyW-1:0]   rem;
  logic [vrt_pkg::EnergyW-1:0]   din;
  logic [vrt_pkg::EnergyW-1:0]   quo;
  logic [vrt_pkg::BetaW+1:0]     sq_rem;
  logic [vrt_pkg::BetaW-1:0]     root;

  // Velocity stage.
  logic [ProdW-1:0]              vprod;
  logic                          vneg;
  logic                          varmed;
  logic [vrt_pkg::VelW-1:0]      vraw;

  logic [vrt_pkg::CountW+1:0]    n3;
  logic [NumW-1:0]               mul_res;
  logic [vrt_pkg::EnergyW:0]     rs;
  logic [vrt_pkg::EnergyW:0]     rs_diff;
  logic                          rs_ge;
  logic [vrt_pkg::BetaW+2:0]     sq_rs;
  logic [vrt_pkg::BetaW+2:0]     sq_trial;
  logic [vrt_pkg::BetaW+2:0]     sq_diff;
  logic                          sq_ge;
  logic [vrt_pkg::VelW-1:0]      vbits;
  logic [vrt_pkg::VelW-1:0]      vmag;
  logic [ProdW:0]                vround;
  logic [ProdW-20:0]             m;
  logic [vrt_pkg::VelW-1:0]      mneg;
  logic [vrt_pkg::VelW-1:0]      vscaled;
  logic [vrt_pkg::VelW-1:0]      vsel;

  always_comb begin
    n3      = {2'b00, count} + {1'b0, count, 1'b0};
    mul_res = target * n3;

    // The quotient fits 48 bits exactly when num < ek * 2^9; otherwise the
    // ratio has overflowed (zero energy included) and beta saturates.
    status.sat       = num >= {1'b0, ek, 9'b0};
    status.due       = enable && (item.sim_time > nft);
    status.item_mode = item.mode;
    status.out_free  = !result_valid || !result_stall;

    rs      = {rem, din[vrt_pkg::EnergyW-1]};
    rs_ge   = rs >= {1'b0, ek};
    rs_diff = rs - {1'b0, ek};

    sq_rs    = {sq_rem[vrt_pkg::BetaW:0], quo[vrt_pkg::EnergyW-1 -: 2]};
    sq_trial = {1'b0, root, 2'b01};
    sq_ge    = sq_rs >= sq_trial;
    sq_diff  = sq_rs - sq_trial;

    vbits = item.velocity_in;
    vmag  = vbits[vrt_pkg::VelW-1] ? (~vbits + 32'd1) : vbits;

    // Round half away from zero on the magnitude, then saturate.
    vround = {1'b0, vprod} + (ProdW+1)'(1 << 19);
    m      = vround[ProdW:20];
    if (vneg) begin
      mneg    = (m > (ProdW-19)'(32'h8000_0000)) ? 32'h8000_0000 : m[vrt_pkg::VelW-1:0];
      vscaled = ~mneg + 32'd1;
    end else begin
      mneg    = m[vrt_pkg::VelW-1:0];
      vscaled = (m > (ProdW-19)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[vrt_pkg::VelW-1:0];
    end
    vsel = varmed ? vscaled : vraw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      target       <= '0;
      interval     <= vrt_pkg::FireIntervalReset;
      count        <= vrt_pkg::ParticleCountReset;
      nft          <= '0;
      sf           <= vrt_pkg::BetaOne;
      armed        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (vrt_pkg::cfg_idx_t'(cfg_index))
          vrt_pkg::CFG_ENABLE:   enable   <= cfg_data[0];
          vrt_pkg::CFG_TARGET:   target   <= cfg_data[vrt_pkg::TempW-1:0];
          vrt_pkg::CFG_INTERVAL: interval <= cfg_data[vrt_pkg::TimeW-1:0];
          vrt_pkg::CFG_COUNT:    count    <= cfg_data[vrt_pkg::CountW-1:0];
          default: ;
        endcase
      end

      if (cmd.beg_load) begin
        armed <= 1'b0;
      end
      if (cmd.sat_fin) begin
        sf    <= vrt_pkg::BetaMax;
        nft   <= nft + interval;
        armed <= 1'b1;
      end
      if (cmd.fin) begin
        sf    <= root;
        nft   <= nft + interval;
        armed <= 1'b1;
      end

      if (cmd.out_vel || cmd.out_beg) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.beg_load) begin
      ek <= item.kinetic_energy;
    end
    if (cmd.mul_go) begin
      num <= mul_res;
    end
    if (cmd.div_init) begin
      rem    <= num[vrt_pkg::EnergyW+8:9];
      din    <= {num[8:0], 39'd0};
      quo    <= '0;
      sq_rem <= '0;
      root   <= '0;
    end
    if (cmd.div_step) begin
      rem <= rs_ge ? rs_diff[vrt_pkg::EnergyW-1:0] : rs[vrt_pkg::EnergyW-1:0];
      din <= {din[vrt_pkg::EnergyW-2:0], 1'b0};
      quo <= {quo[vrt_pkg::EnergyW-2:0], rs_ge};
    end
    if (cmd.sqrt_step) begin
      sq_rem <= sq_ge ? sq_diff[vrt_pkg::BetaW+1:0] : sq_rs[vrt_pkg::BetaW+1:0];
      root   <= {root[vrt_pkg::BetaW-2:0], sq_ge};
      quo    <= {quo[vrt_pkg::EnergyW-3:0], 2'b00};
    end
    if (cmd.vel_load) begin
      vprod  <= vmag * sf;
      vneg   <= vbits[vrt_pkg::VelW-1];
      varmed <= armed;
      vraw   <= vbits;
    end
    if (cmd.out_vel) begin
      result.velocity_out     <= vsel;
      result.fired            <= varmed;
      result.scale_factor_out <= sf;
    end
    if (cmd.out_beg) begin
      result.velocity_out     <= '0;
      result.fired            <= armed;
      result.scale_factor_out <= sf;
    end
  end

endmodule

`default_nettype wire
